>>> hdl/music_port_to_psg_bridge_core_macros.svh
// Assertion macros used by the bridge top level.
`ifndef MUSIC_PORT_TO_PSG_BRIDGE_CORE_MACROS_SVH
`define MUSIC_PORT_TO_PSG_BRIDGE_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MPB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MPB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mpb_pkg.sv
`default_nettype none

package mpb_pkg;

    localparam int CHAN_W              = 3;
    localparam int DRIVEN_CHANNELS_DEF = 3;
    localparam int TEMPO_W             = 16;
    localparam int PERIOD_W            = 12;
    localparam int QUEUE_DEPTH         = 2;
    localparam int PITCH_ENTRIES       = 113;

    localparam logic [7:0] PORT_CH0    = 8'h10;
    localparam logic [7:0] PORT_CH1    = 8'h11;
    localparam logic [7:0] PORT_CH2    = 8'h12;
    localparam logic [7:0] PORT_CH3    = 8'h14;
    localparam logic [7:0] PORT_CH4    = 8'h15;
    localparam logic [7:0] PORT_CH5    = 8'h16;
    localparam logic [7:0] PORT_KEY    = 8'h18;
    localparam logic [7:0] PORT_STATUS = 8'h1A;

    localparam logic [3:0] MIXER_REG   = 4'd7;
    localparam logic [3:0] VOLUME_BASE = 4'd8;
    localparam logic [7:0] MIXER_VALUE = 8'h38;
    localparam logic [7:0] ON_VOLUME   = 8'd14;
    localparam logic [7:0] LEVEL_HIGH  = 8'hF0;

    typedef enum logic [1:0] {
        OP_READ,
        OP_MUTE,
        OP_NOTE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [CHAN_W-1:0]   chan;
        logic [PERIOD_W-1:0] period;
        logic                level;
    } cmd_t;

    typedef struct packed {
        logic                hit;
        logic [PERIOD_W-1:0] period;
    } lookup_t;

    localparam logic [15:0] PITCH_WORDS [PITCH_ENTRIES] = '{
        16'h9741, 16'h8EBE, 16'h86BB, 16'h7F2E, 16'h780B, 16'h714E, 16'h6AED, 16'h64EC,
        16'h5F41, 16'h59E8, 16'h54D9, 16'h5015, 16'h4B95, 16'h4754, 16'h4353, 16'h3F8D,
        16'h3BFC, 16'h389E, 16'h356E, 16'h326E, 16'h2F99, 16'h2CED, 16'h2A66, 16'h2805,
        16'h25C5, 16'h23A5, 16'h21A5, 16'h1FC3, 16'h1DFB, 16'h1C4C, 16'h1AB4, 16'h1934,
        16'h17CA, 16'h1674, 16'h1531, 16'h1401, 16'h12E1, 16'h11D1, 16'h10D1, 16'h0FE1,
        16'h0EFD, 16'h0E25, 16'h0D59, 16'h0C99, 16'h0BE4, 16'h0B39, 16'h0A98, 16'h0A00,
        16'h0970, 16'h08E8, 16'h0868, 16'h07F0, 16'h077E, 16'h0712, 16'h06AC, 16'h064C,
        16'h05F2, 16'h059C, 16'h054C, 16'h0500, 16'h04B8, 16'h0474, 16'h0434, 16'h03F8,
        16'h03BF, 16'h0389, 16'h0356, 16'h0326, 16'h02F9, 16'h02CE, 16'h02A6, 16'h0280,
        16'h025C, 16'h023A, 16'h021A, 16'h01FC, 16'h01DF, 16'h01C4, 16'h01AB, 16'h0193,
        16'h017C, 16'h0167, 16'h0153, 16'h0140, 16'h012E, 16'h011D, 16'h010D, 16'h00FE,
        16'h00F0, 16'h00E2, 16'h00D5, 16'h00C9, 16'h00BE, 16'h00B3, 16'h00A9, 16'h00A0,
        16'h0097, 16'h008E, 16'h0086, 16'h007F, 16'h0078, 16'h0071, 16'h006A, 16'h0064,
        16'h005F, 16'h0059, 16'h0054, 16'h0050, 16'h004B, 16'h0047, 16'h0043, 16'h003F,
        16'h003C
    };

    localparam logic [PERIOD_W-1:0] BASE_PERIOD [12] = '{
        12'hEE8, 12'hE12, 12'hD48, 12'hC88, 12'hBD4, 12'hB2A,
        12'hA8A, 12'h9F2, 12'h964, 12'h8DC, 12'h85E, 12'h7E6
    };

    // The pitch words are all distinct, so at most one entry matches.
    function automatic lookup_t pitch_lookup(input logic [15:0] word);
        lookup_t res;
        res = '0;
        for (int i = 0; i < PITCH_ENTRIES; i++)
        begin
            if (word == PITCH_WORDS[i])
            begin
                res.hit = 1'b1;
                if ((i / 12) < 8)
                begin
                    res.period = res.period | (BASE_PERIOD[i % 12] >> (i / 12));
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/mpb_mod_unit.sv
`default_nettype none

module mpb_mod_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [mpb_pkg::TEMPO_W-1:0] dividend,
    input  wire logic [mpb_pkg::TEMPO_W-1:0] divisor,
    output logic                             busy,
    output logic                             done,
    output logic [mpb_pkg::TEMPO_W-1:0]      remainder
);
    import mpb_pkg::*;

    localparam int CNT_W = $clog2(TEMPO_W);

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TEMPO_W-1:0] rem_reg, rem_next;
    logic [TEMPO_W-1:0] dvd_reg, dvd_next;
    logic [TEMPO_W-1:0] dvs_reg, dvs_next;
    logic [TEMPO_W:0]   trial;
    logic [TEMPO_W:0]   diff;
    logic               fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        trial = {rem_reg, dvd_reg[TEMPO_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
        done  = busy_reg && (cnt_reg == CNT_W'(TEMPO_W - 1));
        remainder = fits ? diff[TEMPO_W-1:0] : trial[TEMPO_W-1:0];

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = remainder;
            dvd_next = {dvd_reg[TEMPO_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> hdl/mpb_front.sv
`default_nettype none

module mpb_front #(
    parameter int DRIVEN_CHANNELS = mpb_pkg::DRIVEN_CHANNELS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        action,
    input  wire logic [7:0]                  port,
    input  wire logic [7:0]                  write_data,
    input  wire logic                        cfg_we,
    input  wire logic [mpb_pkg::TEMPO_W-1:0] cfg_wdata,
    input  wire logic                        q_full,
    output logic                             push,
    output mpb_pkg::cmd_t                    push_cmd,
    output logic                             mod_busy
);
    import mpb_pkg::*;

    logic               high_byte_expected_reg, high_byte_expected_next;
    logic [7:0]         saved_low_byte_reg, saved_low_byte_next;
    logic               key_on_reg, key_on_next;
    logic [TEMPO_W-1:0] read_count_reg, read_count_next;
    logic [TEMPO_W-1:0] rem_reg, rem_next;
    logic               tempo_level_reg, tempo_level_next;
    logic [TEMPO_W-1:0] tempo_period_reg, tempo_period_next;

    logic               accept;
    logic               is_chan;
    logic [CHAN_W-1:0]  chan;
    logic [TEMPO_W-1:0] count_inc;
    logic [TEMPO_W:0]   rem_inc;
    logic               toggle;
    lookup_t            lk;
    logic               mod_done;
    logic [TEMPO_W-1:0] mod_rem;

    mpb_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_we),
        .dividend  (read_count_reg),
        .divisor   (tempo_period_next),
        .busy      (mod_busy),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_byte_expected_reg <= 1'b0;
            saved_low_byte_reg     <= '0;
            key_on_reg             <= 1'b0;
            read_count_reg         <= '0;
            rem_reg                <= '0;
            tempo_level_reg        <= 1'b1;
            tempo_period_reg       <= TEMPO_W'(1);
        end
        else
        begin
            high_byte_expected_reg <= high_byte_expected_next;
            saved_low_byte_reg     <= saved_low_byte_next;
            key_on_reg             <= key_on_next;
            read_count_reg         <= read_count_next;
            rem_reg                <= rem_next;
            tempo_level_reg        <= tempo_level_next;
            tempo_period_reg       <= tempo_period_next;
        end
    end

    always_comb
    begin
        is_chan = 1'b1;
        chan    = '0;
        case (port)
            PORT_CH0: chan = CHAN_W'(0);
            PORT_CH1: chan = CHAN_W'(1);
            PORT_CH2: chan = CHAN_W'(2);
            PORT_CH3: chan = CHAN_W'(3);
            PORT_CH4: chan = CHAN_W'(4);
            PORT_CH5: chan = CHAN_W'(5);
            default:  is_chan = 1'b0;
        endcase
    end

    always_comb
    begin
        in_ready  = !q_full && !mod_busy;
        accept    = in_valid && in_ready;
        count_inc = read_count_reg + 1'b1;
        rem_inc   = {1'b0, rem_reg} + 1'b1;
        toggle    = (count_inc == '0) || (rem_inc == {1'b0, tempo_period_reg});
        lk        = pitch_lookup({write_data, saved_low_byte_reg});

        high_byte_expected_next = high_byte_expected_reg;
        saved_low_byte_next     = saved_low_byte_reg;
        key_on_next             = key_on_reg;
        read_count_next         = read_count_reg;
        rem_next                = rem_reg;
        tempo_level_next        = tempo_level_reg;
        tempo_period_next       = tempo_period_reg;

        push          = 1'b0;
        push_cmd      = '0;
        push_cmd.chan = chan;

        if (cfg_we)
        begin
            tempo_period_next = (cfg_wdata == '0) ? TEMPO_W'(1) : cfg_wdata;
        end
        if (mod_done)
        begin
            rem_next = mod_rem;
        end

        if (accept)
        begin
            if (action)
            begin
                if (port == PORT_STATUS)
                begin
                    if (toggle)
                    begin
                        read_count_next  = '0;
                        rem_next         = '0;
                        tempo_level_next = !tempo_level_reg;
                    end
                    else
                    begin
                        read_count_next = count_inc;
                        rem_next        = rem_inc[TEMPO_W-1:0];
                    end
                    push           = 1'b1;
                    push_cmd.op    = OP_READ;
                    push_cmd.level = tempo_level_next;
                end
            end
            else if (port == PORT_KEY)
            begin
                key_on_next = !write_data[7];
            end
            else if (is_chan)
            begin
                if (!high_byte_expected_reg)
                begin
                    saved_low_byte_next     = write_data;
                    high_byte_expected_next = 1'b1;
                end
                else
                begin
                    high_byte_expected_next = 1'b0;
                    if (chan < CHAN_W'(DRIVEN_CHANNELS))
                    begin
                        push = 1'b1;
                        if (key_on_reg && lk.hit)
                        begin
                            push_cmd.op     = OP_NOTE;
                            push_cmd.period = lk.period;
                        end
                        else
                        begin
                            push_cmd.op = OP_MUTE;
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/mpb_cmd_queue.sv
`default_nettype none

module mpb_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mpb_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               q_valid,
    output mpb_pkg::cmd_t      q_cmd
);
    import mpb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_comb
    begin
        full    = (count_reg == CNT_W'(QUEUE_DEPTH));
        q_valid = (count_reg != '0);
        q_cmd   = entry_reg[rd_ptr_reg];
        do_push = push && !full;
        do_pop  = pop && q_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

endmodule

`default_nettype wire

>>> hdl/mpb_back.sv
`default_nettype none

module mpb_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire mpb_pkg::cmd_t q_cmd,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               kind,
    output logic [3:0]         chip_register,
    output logic [7:0]         chip_value,
    output logic [7:0]         read_data,
    output logic               last
);
    import mpb_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] step_reg, step_next;
    logic       kind_reg, kind_next;
    logic [3:0] chip_register_reg, chip_register_next;
    logic [7:0] chip_value_reg, chip_value_next;
    logic [7:0] read_data_reg, read_data_next;
    logic       last_reg, last_next;
    logic       load;
    logic [3:0] chan4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg          <= kind_next;
        chip_register_reg <= chip_register_next;
        chip_value_reg    <= chip_value_next;
        read_data_reg     <= read_data_next;
        last_reg          <= last_next;
    end

    always_comb
    begin
        load  = !out_valid_reg || out_ready;
        chan4 = 4'(q_cmd.chan);

        out_valid_next     = out_valid_reg;
        step_next          = step_reg;
        kind_next          = kind_reg;
        chip_register_next = chip_register_reg;
        chip_value_next    = chip_value_reg;
        read_data_next     = read_data_reg;
        last_next          = last_reg;
        pop                = 1'b0;

        if (load)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                kind_next          = 1'b0;
                chip_register_next = '0;
                chip_value_next    = '0;
                read_data_next     = '0;
                last_next          = 1'b1;
                case (q_cmd.op)
                    OP_READ:
                    begin
                        kind_next      = 1'b1;
                        read_data_next = q_cmd.level ? LEVEL_HIGH : 8'h00;
                    end
                    OP_NOTE:
                    begin
                        last_next = (step_reg == 2'd3);
                        case (step_reg)
                            2'd0:
                            begin
                                chip_register_next = {chan4[2:0], 1'b0};
                                chip_value_next    = q_cmd.period[7:0];
                            end
                            2'd1:
                            begin
                                chip_register_next = {chan4[2:0], 1'b1};
                                chip_value_next    = 8'(q_cmd.period[PERIOD_W-1:8]);
                            end
                            2'd2:
                            begin
                                chip_register_next = MIXER_REG;
                                chip_value_next    = MIXER_VALUE;
                            end
                            default:
                            begin
                                chip_register_next = VOLUME_BASE + chan4;
                                chip_value_next    = ON_VOLUME;
                            end
                        endcase
                    end
                    default:
                    begin
                        chip_register_next = VOLUME_BASE + chan4;
                    end
                endcase
                pop       = last_next;
                step_next = last_next ? 2'd0 : step_reg + 2'd1;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign chip_register = chip_register_reg;
    assign chip_value    = chip_value_reg;
    assign read_data     = read_data_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

>>> hdl/music_port_to_psg_bridge_core.sv
// A result passes the queue, then the back-end output register; a note gives four results.
// Throughput: one transaction per cycle in and one result per cycle out, unless in_ready or out_ready is low.
// A note holds the back end for its four results; a two-entry queue absorbs bursts.
// A tempo write blocks input while the remainder is recomputed bit by bit.
// Reset (rst_n, asynchronous, active low) empties the queue, clears out_valid and the control state, not data regs.
`default_nettype none
`include "music_port_to_psg_bridge_core_macros.svh"

module music_port_to_psg_bridge_core #(
    parameter int DRIVEN_CHANNELS = mpb_pkg::DRIVEN_CHANNELS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        action,
    input  wire logic [7:0]                  port,
    input  wire logic [7:0]                  write_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             kind,
    output logic [3:0]                       chip_register,
    output logic [7:0]                       chip_value,
    output logic [7:0]                       read_data,
    output logic                             last,
    input  wire logic                        cfg_we,
    input  wire logic [mpb_pkg::TEMPO_W-1:0] cfg_wdata
);
    import mpb_pkg::*;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;
    logic mod_busy;

    mpb_front #(
        .DRIVEN_CHANNELS (DRIVEN_CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .port       (port),
        .write_data (write_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .mod_busy   (mod_busy)
    );

    mpb_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    mpb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .chip_register (chip_register),
        .chip_value    (chip_value),
        .read_data     (read_data),
        .last          (last)
    );

    `MPB_ASSERT_IMP(a_busy_blocks_input, mod_busy, !in_ready, "input taken during remainder update")
    `MPB_ASSERT_IMP(a_full_blocks_input, q_full, !in_ready, "input taken while queue full")
    `MPB_ASSERT_IMP(a_read_result_shape, out_valid && kind,
        (chip_register == 4'd0) && (chip_value == 8'd0) && last, "malformed read result")
    `MPB_ASSERT_IMP(a_write_result_shape, out_valid && !kind, read_data == 8'd0,
        "read data set on a chip write")
    `MPB_ASSERT_NXT(a_cfg_starts_update, cfg_we, mod_busy, "tempo write did not start update")

endmodule

`default_nettype wire
